### hw/rtl/i2cm_pkg.sv
// ============================================================================
// i2cm_pkg
// Types, constants and helpers shared by the I2C master controller files.
// ============================================================================
package i2cm_pkg;

  // Counter widths
  localparam int DELAY_BITS = 16;
  localparam int COUNT_BITS = 8;

  // Field widths fixed by the bus protocol and register map
  localparam int HALF_W     = 16;
  localparam int ADDR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int BITCNT_W   = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 1'b0,
    CFG_DEV_ADDR    = 1'b1
  } cfg_idx_t;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;
  localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd0;

  // Bus sequencer phases, one-hot
  typedef enum logic [20:0] {
    PH_IDLE     = 21'h000001,
    PH_ST_HOLD  = 21'h000002,
    PH_ST_SETUP = 21'h000004,
    PH_W_LOW    = 21'h000008,
    PH_W_RISE   = 21'h000010,
    PH_W_HIGH   = 21'h000020,
    PH_A_LOW    = 21'h000040,
    PH_A_RISE   = 21'h000080,
    PH_A_HIGH   = 21'h000100,
    PH_A_TAIL   = 21'h000200,
    PH_R_LOW    = 21'h000400,
    PH_R_RISE   = 21'h000800,
    PH_R_HIGH   = 21'h001000,
    PH_K_LOW    = 21'h002000,
    PH_K_RISE   = 21'h004000,
    PH_K_HIGH   = 21'h008000,
    PH_K_TAIL   = 21'h010000,
    PH_P_LOW    = 21'h020000,
    PH_P_RISE   = 21'h040000,
    PH_P_HIGH   = 21'h080000,
    PH_P_TAIL   = 21'h100000
  } phase_t;

  // One tick of inputs
  typedef struct packed {
    logic              cmd_valid;
    logic              func;
    logic [BYTE_W-1:0] byte_count;
    logic [BYTE_W-1:0] wr_byte;
    logic              sda_in;
    logic              scl_in;
  } req_t;

  // One tick of outputs
  typedef struct packed {
    logic              scl_drive_low;
    logic              sda_drive_low;
    logic              wr_taken;
    logic              rd_valid;
    logic [BYTE_W-1:0] rd_byte;
    logic              busy_res;
    logic              done_res;
    logic              nack;
  } rsp_t;

  // Sequencer state
  typedef struct packed {
    phase_t                phase;
    logic [DELAY_BITS-1:0] delay_count;
    logic [BITCNT_W-1:0]   bit_count;
    logic [COUNT_BITS-1:0] bytes_left;
    logic [BYTE_W-1:0]     shift_reg;
    logic                  is_read;
    logic                  nack_flag;
    logic                  scl_low;
    logic                  sda_low;
  } state_t;

  // Settings seen by the sequencer
  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic [ADDR_W-1:0] device_address;
  } cfg_t;

  // Delay load: zero acts as one, too large saturates
  function automatic logic [DELAY_BITS-1:0] delay_load(input logic [HALF_W-1:0] hp);
    logic [DELAY_BITS-1:0] v;
    if (hp == '0) begin
      v = DELAY_BITS'(1);
    end else if ((32'(hp) >> DELAY_BITS) != 32'd0) begin
      v = '1;
    end else begin
      v = DELAY_BITS'(hp);
    end
    return v;
  endfunction

  // Byte count saturated to the counter width
  function automatic logic [COUNT_BITS-1:0] count_load(input logic [BYTE_W-1:0] bc);
    logic [COUNT_BITS-1:0] v;
    if ((32'(bc) >> COUNT_BITS) != 32'd0) begin
      v = '1;
    end else begin
      v = COUNT_BITS'(bc);
    end
    return v;
  endfunction

endpackage

### hw/rtl/i2cm_req_if.sv
// ============================================================================
// i2cm_req_if
// Input channel: one tick of command and sampled bus lines per beat.
// ============================================================================
interface i2cm_req_if;
  import i2cm_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/i2cm_rsp_if.sv
// ============================================================================
// i2cm_rsp_if
// Output channel: line drives and status for one tick per beat.
// ============================================================================
interface i2cm_rsp_if;
  import i2cm_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/i2cm_fsm.sv
// ============================================================================
// i2cm_fsm
// Next-state and output logic of the bus sequencer for one tick.
// ============================================================================
module i2cm_fsm (
  input  i2cm_pkg::state_t st,
  input  i2cm_pkg::cfg_t   cfg,
  input  i2cm_pkg::req_t   req,
  output i2cm_pkg::state_t nxt,
  output i2cm_pkg::rsp_t   res
);
  import i2cm_pkg::*;

  logic                  dly_done;
  logic [DELAY_BITS-1:0] dly_load;
  logic [DELAY_BITS-1:0] dly_dec;
  logic [BITCNT_W-1:0]   bc_inc;
  logic [BYTE_W-1:0]     sh_left;
  logic [BYTE_W-1:0]     sh_in;
  logic [BYTE_W-1:0]     addr_byte;
  logic                  done;
  logic                  wr_taken;
  logic                  rd_valid;
  logic [BYTE_W-1:0]     rd_byte;

  // Shared helpers
  assign dly_done  = (st.delay_count[DELAY_BITS-1:1] == '0);
  assign dly_load  = delay_load(cfg.half_period_ticks);
  assign dly_dec   = st.delay_count - DELAY_BITS'(1);
  assign bc_inc    = st.bit_count + BITCNT_W'(1);
  assign sh_left   = {st.shift_reg[BYTE_W-2:0], 1'b0};
  assign sh_in     = {st.shift_reg[BYTE_W-2:0], req.sda_in};
  assign addr_byte = {cfg.device_address, st.is_read};

  // Phase transitions
  always_comb begin
    nxt      = st;
    done     = 1'b0;
    wr_taken = 1'b0;
    rd_valid = 1'b0;
    rd_byte  = '0;
    case (st.phase)
      PH_IDLE: begin
        if (req.cmd_valid) begin
          nxt.is_read     = req.func;
          nxt.bytes_left  = count_load(req.byte_count);
          nxt.nack_flag   = 1'b0;
          nxt.scl_low     = 1'b0;
          nxt.sda_low     = 1'b1;
          nxt.delay_count = dly_load;
          nxt.phase       = PH_ST_HOLD;
        end
      end
      PH_ST_HOLD: begin
        if (dly_done) begin
          nxt.scl_low     = 1'b1;
          nxt.delay_count = dly_load;
          nxt.phase       = PH_ST_SETUP;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_ST_SETUP: begin
        if (dly_done) begin
          nxt.shift_reg   = addr_byte;
          nxt.bit_count   = '0;
          nxt.sda_low     = ~addr_byte[BYTE_W-1];
          nxt.delay_count = dly_load;
          nxt.phase       = PH_W_LOW;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_W_LOW: begin
        if (dly_done) begin
          nxt.scl_low = 1'b0;
          nxt.phase   = PH_W_RISE;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_W_RISE: begin
        if (req.scl_in) begin
          nxt.delay_count = dly_load;
          nxt.phase       = PH_W_HIGH;
        end
      end
      PH_W_HIGH: begin
        if (dly_done) begin
          nxt.scl_low     = 1'b1;
          nxt.shift_reg   = sh_left;
          nxt.bit_count   = bc_inc;
          nxt.delay_count = dly_load;
          if (bc_inc[BITCNT_W-1]) begin
            nxt.phase = PH_A_LOW;
          end else begin
            nxt.sda_low = ~sh_left[BYTE_W-1];
            nxt.phase   = PH_W_LOW;
          end
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_A_LOW: begin
        if (dly_done) begin
          nxt.sda_low = 1'b0;
          nxt.scl_low = 1'b0;
          nxt.phase   = PH_A_RISE;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_A_RISE: begin
        if (req.scl_in) begin
          nxt.delay_count = dly_load;
          nxt.phase       = PH_A_HIGH;
        end
      end
      PH_A_HIGH: begin
        if (dly_done) begin
          if (req.sda_in) begin
            nxt.nack_flag = 1'b1;
          end
          nxt.scl_low     = 1'b1;
          nxt.delay_count = dly_load;
          nxt.phase       = PH_A_TAIL;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_A_TAIL: begin
        if (dly_done) begin
          nxt.delay_count = dly_load;
          if (st.bytes_left == '0) begin
            nxt.sda_low = 1'b1;
            nxt.phase   = PH_P_LOW;
          end else if (!st.is_read) begin
            wr_taken       = 1'b1;
            nxt.shift_reg  = req.wr_byte;
            nxt.bytes_left = st.bytes_left - COUNT_BITS'(1);
            nxt.bit_count  = '0;
            nxt.sda_low    = ~req.wr_byte[BYTE_W-1];
            nxt.phase      = PH_W_LOW;
          end else begin
            nxt.sda_low    = 1'b0;
            nxt.bit_count  = '0;
            nxt.shift_reg  = '0;
            nxt.bytes_left = st.bytes_left - COUNT_BITS'(1);
            nxt.phase      = PH_R_LOW;
          end
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_R_LOW: begin
        if (dly_done) begin
          nxt.scl_low = 1'b0;
          nxt.phase   = PH_R_RISE;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_R_RISE: begin
        if (req.scl_in) begin
          nxt.delay_count = dly_load;
          nxt.phase       = PH_R_HIGH;
        end
      end
      PH_R_HIGH: begin
        if (dly_done) begin
          nxt.shift_reg   = sh_in;
          nxt.bit_count   = bc_inc;
          nxt.scl_low     = 1'b1;
          nxt.delay_count = dly_load;
          if (bc_inc[BITCNT_W-1]) begin
            rd_valid    = 1'b1;
            rd_byte     = sh_in;
            // ACK unless this was the last byte
            nxt.sda_low = (st.bytes_left != '0);
            nxt.phase   = PH_K_LOW;
          end else begin
            nxt.phase = PH_R_LOW;
          end
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_K_LOW: begin
        if (dly_done) begin
          nxt.scl_low = 1'b0;
          nxt.phase   = PH_K_RISE;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_K_RISE: begin
        if (req.scl_in) begin
          nxt.delay_count = dly_load;
          nxt.phase       = PH_K_HIGH;
        end
      end
      PH_K_HIGH: begin
        if (dly_done) begin
          nxt.scl_low     = 1'b1;
          nxt.delay_count = dly_load;
          if (st.bytes_left != '0) begin
            nxt.sda_low    = 1'b0;
            nxt.bit_count  = '0;
            nxt.shift_reg  = '0;
            nxt.bytes_left = st.bytes_left - COUNT_BITS'(1);
            nxt.phase      = PH_R_LOW;
          end else begin
            nxt.phase = PH_K_TAIL;
          end
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_K_TAIL: begin
        if (dly_done) begin
          nxt.sda_low     = 1'b1;
          nxt.delay_count = dly_load;
          nxt.phase       = PH_P_LOW;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_P_LOW: begin
        if (dly_done) begin
          nxt.scl_low = 1'b0;
          nxt.phase   = PH_P_RISE;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_P_RISE: begin
        if (req.scl_in) begin
          nxt.delay_count = dly_load;
          nxt.phase       = PH_P_HIGH;
        end
      end
      PH_P_HIGH: begin
        if (dly_done) begin
          // SDA rises while SCL is high: stop condition
          nxt.sda_low     = 1'b0;
          nxt.delay_count = dly_load;
          nxt.phase       = PH_P_TAIL;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      PH_P_TAIL: begin
        if (dly_done) begin
          done      = 1'b1;
          nxt.phase = PH_IDLE;
        end else begin
          nxt.delay_count = dly_dec;
        end
      end
      default: begin
        // illegal code: back to idle, lines released
        nxt.phase       = PH_IDLE;
        nxt.delay_count = '0;
        nxt.bit_count   = '0;
        nxt.bytes_left  = '0;
        nxt.shift_reg   = '0;
        nxt.is_read     = 1'b0;
        nxt.nack_flag   = 1'b0;
        nxt.scl_low     = 1'b0;
        nxt.sda_low     = 1'b0;
      end
    endcase
  end

  // Result of this tick
  always_comb begin
    res.scl_drive_low = nxt.scl_low;
    res.sda_drive_low = nxt.sda_low;
    res.wr_taken      = wr_taken;
    res.rd_valid      = rd_valid;
    res.rd_byte       = rd_byte;
    res.busy_res      = (nxt.phase != PH_IDLE);
    res.done_res      = done;
    res.nack          = done & nxt.nack_flag;
  end

endmodule

### hw/rtl/i2c_master_controller.sv
// ============================================================================
// i2c_master_controller
// I2C master bus sequencer: one beat per bus tick in, one beat per tick out.
// ============================================================================
//
//  port  | dir | beat contents
//  ------+-----+---------------------------------------------------------
//  req   | in  | cmd_valid, func, byte_count, wr_byte, sda_in, scl_in
//  rsp   | out | scl/sda drive-low, wr_taken, rd_valid, rd_byte, busy, done, nack
//  cfg   | in  | write enable, register index, write data
//
// Each req beat is one tick and yields exactly one rsp beat in the next cycle,
// through the output register. A new beat is taken every cycle while the
// output register is empty or being drained. A stall on rsp holds req off
// after one beat. Reset (synchronous) puts the sequencer in idle with both
// lines released and the configuration registers at their defaults.
// ============================================================================
module i2c_master_controller (
  input  logic                             clk,
  input  logic                             rst,
  i2cm_req_if.sink                         req,
  i2cm_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cm_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  rsp_t   res_next;
  rsp_t   out_data;
  logic   out_valid;
  logic   accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_RESET;
      cfg.device_address    <= ADDR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data[HALF_W-1:0];
        CFG_DEV_ADDR:    cfg.device_address    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign req.ready = ~out_valid | rsp.ready;
  assign accept    = req.valid & req.ready;

  // Tick logic
  i2cm_fsm u_fsm (
    .st  (st),
    .cfg (cfg),
    .req (req.data),
    .nxt (st_next),
    .res (res_next)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_IDLE;
      st.delay_count <= '0;
      st.bit_count   <= '0;
      st.bytes_left  <= '0;
      st.shift_reg   <= '0;
      st.is_read     <= 1'b0;
      st.nack_flag   <= 1'b0;
      st.scl_low     <= 1'b0;
      st.sda_low     <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Checks
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted beat produced no result");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_IDLE) |-> (!st.scl_low && !st.sda_low))
    else $error("bus line held low while idle");

  a_nack_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && st.phase == PH_IDLE && req.data.cmd_valid) |=> !st.nack_flag)
    else $error("nack flag not cleared at transaction start");

endmodule
